FILE: hw/rtl/tlnb_pkg.sv
// ----------------------------------------------------------------------------
// tlnb_pkg
// Shared types, constants and helpers for the traffic light with night blink.
// ----------------------------------------------------------------------------
package tlnb_pkg;

    // timing constants, in millisecond ticks
    localparam int SECOND_MS   = 1000;
    localparam int DEBOUNCE_MS = 50;

    // field widths
    localparam int DUR_W   = 17;
    localparam int LIGHT_W = 12;
    localparam int CNT_W   = 7;
    localparam int TIME_W  = 32;

    // register file layout
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    typedef enum logic [1:0] {
        REG_RED_MS    = 2'd0,
        REG_YELLOW_MS = 2'd1,
        REG_GREEN_MS  = 2'd2,
        REG_DARK_THR  = 2'd3
    } t_reg_idx;

    // register reset values
    localparam logic [DUR_W-1:0]   RESET_RED_MS    = 17'd7000;
    localparam logic [DUR_W-1:0]   RESET_YELLOW_MS = 17'd5000;
    localparam logic [DUR_W-1:0]   RESET_GREEN_MS  = 17'd10000;
    localparam logic [LIGHT_W-1:0] RESET_DARK_THR  = 12'd1000;

    // countdown cap for a two digit display
    localparam logic [CNT_W-1:0] CNT_MAX = 7'd99;

    // reciprocal of one second, scaled by 2^RECIP_SHIFT, rounded down
    localparam int RECIP_SHIFT = 20;
    localparam logic [RECIP_SHIFT:0] RECIP = (RECIP_SHIFT + 1)'((1 << RECIP_SHIFT) / SECOND_MS);
    localparam int PROD_W = DUR_W + RECIP_SHIFT + 1;

    // phase sequencer states
    typedef enum logic [2:0] {
        PH_RED    = 3'b001,
        PH_GREEN  = 3'b010,
        PH_YELLOW = 3'b100
    } t_phase;

    // register values seen by the core, with precomputed countdown reloads
    typedef struct packed {
        logic [DUR_W-1:0]   red_ms;
        logic [DUR_W-1:0]   yellow_ms;
        logic [DUR_W-1:0]   green_ms;
        logic [LIGHT_W-1:0] dark_thr;
        logic [CNT_W-1:0]   red_reload;
        logic [CNT_W-1:0]   yellow_reload;
        logic [CNT_W-1:0]   green_reload;
    } t_cfg;

    // one result item
    typedef struct packed {
        logic             lamp_red;
        logic             lamp_yellow;
        logic             lamp_green;
        logic             indicator_led;
        logic             display_write;
        logic [CNT_W-1:0] display_digits;
        logic             display_clear;
    } t_result;

    // countdown reload: whole seconds minus one, floored at 0, capped at 99
    // the quotient is estimated through the reciprocal and fixed up once
    function automatic logic [CNT_W-1:0] f_reload(input logic [DUR_W-1:0] dur);
        logic [PROD_W-1:0] prod;
        logic [DUR_W-1:0]  q_est;
        logic [DUR_W-1:0]  q_back;
        logic [DUR_W-1:0]  rem;
        logic [DUR_W-1:0]  quot;
        logic [DUR_W-1:0]  qm1;
        prod   = PROD_W'(dur) * PROD_W'(RECIP);
        q_est  = prod[RECIP_SHIFT +: DUR_W];
        q_back = DUR_W'(q_est * DUR_W'(SECOND_MS));
        rem    = dur - q_back;
        quot   = (rem >= DUR_W'(SECOND_MS)) ? q_est + 1'b1 : q_est;
        qm1    = quot - 1'b1;
        if (quot == '0) begin
            return '0;
        end else if (qm1 > DUR_W'(CNT_MAX)) begin
            return CNT_MAX;
        end else begin
            return qm1[CNT_W-1:0];
        end
    endfunction

    localparam logic [CNT_W-1:0] RESET_RED_RELOAD    = f_reload(RESET_RED_MS);
    localparam logic [CNT_W-1:0] RESET_YELLOW_RELOAD = f_reload(RESET_YELLOW_MS);
    localparam logic [CNT_W-1:0] RESET_GREEN_RELOAD  = f_reload(RESET_GREEN_MS);

endpackage

FILE: hw/rtl/tlnb_cfg.sv
// ----------------------------------------------------------------------------
// tlnb_cfg
// APB register file: phase durations, dark threshold and countdown reloads.
// ----------------------------------------------------------------------------
module tlnb_cfg import tlnb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg             r_cfg;
    t_cfg             n_cfg;
    logic             wr_en;
    t_reg_idx         wr_idx;
    t_reg_idx         rd_idx;
    logic [DUR_W-1:0] wr_dur;
    logic [CNT_W-1:0] wr_reload;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = t_reg_idx'(paddr[3:2]);
    assign rd_idx = t_reg_idx'(paddr[3:2]);

    // reload is worked out once, when the duration is written
    assign wr_dur    = pwdata[DUR_W-1:0];
    assign wr_reload = f_reload(wr_dur);

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (wr_idx)
                REG_RED_MS: begin
                    n_cfg.red_ms     = wr_dur;
                    n_cfg.red_reload = wr_reload;
                end
                REG_YELLOW_MS: begin
                    n_cfg.yellow_ms     = wr_dur;
                    n_cfg.yellow_reload = wr_reload;
                end
                REG_GREEN_MS: begin
                    n_cfg.green_ms     = wr_dur;
                    n_cfg.green_reload = wr_reload;
                end
                REG_DARK_THR: begin
                    n_cfg.dark_thr = pwdata[LIGHT_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.red_ms        <= RESET_RED_MS;
            r_cfg.yellow_ms     <= RESET_YELLOW_MS;
            r_cfg.green_ms      <= RESET_GREEN_MS;
            r_cfg.dark_thr      <= RESET_DARK_THR;
            r_cfg.red_reload    <= RESET_RED_RELOAD;
            r_cfg.yellow_reload <= RESET_YELLOW_RELOAD;
            r_cfg.green_reload  <= RESET_GREEN_RELOAD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // read mux
    always_comb begin
        case (rd_idx)
            REG_RED_MS:    prdata = APB_DW'(r_cfg.red_ms);
            REG_YELLOW_MS: prdata = APB_DW'(r_cfg.yellow_ms);
            REG_GREEN_MS:  prdata = APB_DW'(r_cfg.green_ms);
            REG_DARK_THR:  prdata = APB_DW'(r_cfg.dark_thr);
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/tlnb_core.sv
// ----------------------------------------------------------------------------
// tlnb_core
// Per-tick state update: button debounce, light sense, phase sequencer,
// countdown and night blink.
// ----------------------------------------------------------------------------
module tlnb_core import tlnb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tick,
    input  logic [LIGHT_W-1:0] i_light_level,
    input  logic               i_button_level,
    input  t_cfg               i_cfg,
    output t_result            o_result
);

    localparam logic [TIME_W-1:0] SEC_P = TIME_W'(SECOND_MS);
    localparam logic [TIME_W-1:0] DEB_P = TIME_W'(DEBOUNCE_MS);

    logic [TIME_W-1:0]  r_now,     n_now;
    t_phase             r_phase,   n_phase;
    logic [TIME_W-1:0]  r_ph_st,   n_ph_st;
    logic [TIME_W-1:0]  r_cnt_st,  n_cnt_st;
    logic [CNT_W-1:0]   r_cnt,     n_cnt;
    logic [TIME_W-1:0]  r_sns_st,  n_sns_st;
    logic [LIGHT_W-1:0] r_last_lt, n_last_lt;
    logic               r_night,   n_night;
    logic [TIME_W-1:0]  r_blk_st,  n_blk_st;
    logic               r_blk_lit, n_blk_lit;
    logic               r_yel_nt,  n_yel_nt;
    logic [TIME_W-1:0]  r_btn_st,  n_btn_st;
    logic               r_last_bt, n_last_bt;
    logic               r_disp_on, n_disp_on;

    logic             btn_due;
    logic             sns_due;
    logic             blk_due;
    logic             ph_due;
    logic             cnt_due;
    logic [DUR_W-1:0] ph_dur;
    t_phase           ph_next;
    logic [CNT_W-1:0] ph_reload;
    logic             show;
    logic             clr;
    logic             wr;
    logic [CNT_W-1:0] digits;

    // tick time and timer checks against the new time
    assign n_now   = r_now + 1'b1;
    assign btn_due = (n_now - r_btn_st) >= DEB_P;
    assign sns_due = (n_now - r_sns_st) >= SEC_P;
    assign blk_due = (n_now - r_blk_st) >= SEC_P;
    assign cnt_due = (n_now - r_cnt_st) >= SEC_P;
    assign ph_due  = (n_now - r_ph_st) >= TIME_W'(ph_dur);

    // phase duration and successor
    always_comb begin
        case (r_phase)
            PH_GREEN: begin
                ph_dur    = i_cfg.green_ms;
                ph_next   = PH_YELLOW;
                ph_reload = i_cfg.yellow_reload;
            end
            PH_YELLOW: begin
                ph_dur    = i_cfg.yellow_ms;
                ph_next   = PH_RED;
                ph_reload = i_cfg.red_reload;
            end
            default: begin
                ph_dur    = i_cfg.red_ms;
                ph_next   = PH_GREEN;
                ph_reload = i_cfg.green_reload;
            end
        endcase
    end

    // next state for one tick
    always_comb begin
        n_phase   = r_phase;
        n_ph_st   = r_ph_st;
        n_cnt_st  = r_cnt_st;
        n_cnt     = r_cnt;
        n_sns_st  = r_sns_st;
        n_last_lt = r_last_lt;
        n_night   = r_night;
        n_blk_st  = r_blk_st;
        n_blk_lit = r_blk_lit;
        n_yel_nt  = r_yel_nt;
        n_btn_st  = r_btn_st;
        n_last_bt = r_last_bt;
        n_disp_on = r_disp_on;
        clr       = 1'b0;
        wr        = 1'b0;
        digits    = '0;
        show      = 1'b0;

        // button sampled each debounce period, falling edge toggles display
        if (btn_due) begin
            n_btn_st = n_now;
            if (i_button_level != r_last_bt) begin
                if (!i_button_level) begin
                    clr       = r_disp_on;
                    n_disp_on = !r_disp_on;
                end
                n_last_bt = i_button_level;
            end
        end

        // light sampled once a second, a change selects day or night
        if (sns_due) begin
            n_sns_st = n_now;
            if (i_light_level != r_last_lt) begin
                if (i_light_level < i_cfg.dark_thr) begin
                    if (!r_night) begin
                        n_night  = 1'b1;
                        n_yel_nt = 1'b0;
                        clr      = 1'b1;
                    end
                end else begin
                    n_night = 1'b0;
                end
                n_last_lt = i_light_level;
            end
        end

        if (n_night) begin
            // night blink on yellow
            if (blk_due) begin
                n_blk_st  = n_now;
                n_yel_nt  = !r_blk_lit;
                n_blk_lit = !r_blk_lit;
            end
        end else begin
            // phase sequencing and seconds countdown
            if (ph_due) begin
                n_ph_st  = n_now;
                n_phase  = ph_next;
                n_cnt    = ph_reload;
                n_cnt_st = n_now;
                show     = 1'b1;
            end else if (cnt_due) begin
                n_cnt_st = n_now;
                show     = 1'b1;
            end
            if (show) begin
                if (n_disp_on) begin
                    wr     = 1'b1;
                    digits = n_cnt;
                end
                if (n_cnt != '0) begin
                    n_cnt = n_cnt - 1'b1;
                end
            end
        end
    end

    // result of this tick
    always_comb begin
        o_result.lamp_red       = !n_night && (n_phase != PH_GREEN) && (n_phase != PH_YELLOW);
        o_result.lamp_yellow    = n_night ? n_yel_nt : (n_phase == PH_YELLOW);
        o_result.lamp_green     = !n_night && (n_phase == PH_GREEN);
        o_result.indicator_led  = n_disp_on;
        o_result.display_write  = wr;
        o_result.display_digits = digits;
        o_result.display_clear  = clr;
    end

    // state registers, advanced once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now     <= '0;
            r_phase   <= PH_RED;
            r_ph_st   <= '0;
            r_cnt_st  <= '0;
            r_cnt     <= RESET_RED_RELOAD;
            r_sns_st  <= '0;
            r_last_lt <= RESET_DARK_THR;
            r_night   <= 1'b0;
            r_blk_st  <= '0;
            r_blk_lit <= 1'b0;
            r_yel_nt  <= 1'b0;
            r_btn_st  <= '0;
            r_last_bt <= 1'b1;
            r_disp_on <= 1'b1;
        end else if (i_tick) begin
            r_now     <= n_now;
            r_phase   <= n_phase;
            r_ph_st   <= n_ph_st;
            r_cnt_st  <= n_cnt_st;
            r_cnt     <= n_cnt;
            r_sns_st  <= n_sns_st;
            r_last_lt <= n_last_lt;
            r_night   <= n_night;
            r_blk_st  <= n_blk_st;
            r_blk_lit <= n_blk_lit;
            r_yel_nt  <= n_yel_nt;
            r_btn_st  <= n_btn_st;
            r_last_bt <= n_last_bt;
            r_disp_on <= n_disp_on;
        end
    end

endmodule

FILE: hw/rtl/traffic_light_with_night_blink.sv
// ----------------------------------------------------------------------------
// traffic_light_with_night_blink
// Red/green/yellow sequencer with seconds countdown and night blink mode.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall): one transfer per millisecond tick,
//   carrying the light sensor sample and the raw button level.
//   Output channel (o_valid / i_stall): one transfer per tick with the lamp
//   drives, indicator LED and display strobes for that tick.
//   Configuration over APB: red, yellow and green durations in ms at 0x0,
//   0x4, 0x8 and the dark threshold at 0xC; write only while idle.
// Path: an input transfer is held in the input register, then the state
//   update logic writes the result register, which raises o_valid.
// Throughput: 1 tick per cycle unless the output stalls; the state update is a
//   single pass of compare-and-select logic over the timer registers.
// Reset: synchronous, active low. All timers clear, phase is red, countdown
//   is loaded from the red duration, display is enabled, registers take
//   their reset durations and threshold.
// Stall: a stalled result holds in the output register; one more tick is
//   taken into the input register, then o_stall rises until the result
//   drains.
// ----------------------------------------------------------------------------
module traffic_light_with_night_blink import tlnb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // tick input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [LIGHT_W-1:0] i_light_level,
    input  logic               i_button_level,
    // result output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_lamp_red,
    output logic               o_lamp_yellow,
    output logic               o_lamp_green,
    output logic               o_indicator_led,
    output logic               o_display_write,
    output logic [CNT_W-1:0]   o_display_digits,
    output logic               o_display_clear,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    logic               r_in_valid;
    logic [LIGHT_W-1:0] r_light;
    logic               r_button;
    logic               r_out_valid;
    t_result            r_out;

    logic    in_take;
    logic    out_free;
    logic    tick;
    t_cfg    cfg;
    t_result result;

    // handshake: process when the output register is free or draining
    assign out_free = !r_out_valid || !i_stall;
    assign tick     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    tlnb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tlnb_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tick         (tick),
        .i_light_level  (r_light),
        .i_button_level (r_button),
        .i_cfg          (cfg),
        .o_result       (result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (tick) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_light  <= i_light_level;
            r_button <= i_button_level;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tick) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick) begin
            r_out <= result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_lamp_red       = r_out.lamp_red;
    assign o_lamp_yellow    = r_out.lamp_yellow;
    assign o_lamp_green     = r_out.lamp_green;
    assign o_indicator_led  = r_out.indicator_led;
    assign o_display_write  = r_out.display_write;
    assign o_display_digits = r_out.display_digits;
    assign o_display_clear  = r_out.display_clear;

endmodule

FILE: hw/rtl/tlnb_checker.sv
// ----------------------------------------------------------------------------
// tlnb_checker
// Port-level checks for the traffic light with night blink, bound to the top.
// ----------------------------------------------------------------------------
module tlnb_checker import tlnb_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_valid,
    input logic             i_stall,
    input logic             o_lamp_red,
    input logic             o_lamp_yellow,
    input logic             o_lamp_green,
    input logic             o_display_write,
    input logic [CNT_W-1:0] o_display_digits
);

    // a stalled result transfer holds its digits
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_display_digits))
        else $error("result changed while stalled");

    // never more than one lamp lit
    a_one_lamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $countones({o_lamp_red, o_lamp_yellow, o_lamp_green}) <= 1)
        else $error("more than one lamp lit");

    // digits are zero unless a display write is strobed
    a_digits_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_display_write |-> o_display_digits == '0)
        else $error("digits without display write");

    // written countdown fits two digits
    a_digits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_display_write |-> o_display_digits <= CNT_MAX)
        else $error("countdown beyond two digits");

    // a display write only comes with a day lamp lit
    a_write_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_display_write |-> o_lamp_red || o_lamp_green || o_lamp_yellow)
        else $error("display write while dark");

endmodule

bind traffic_light_with_night_blink tlnb_checker u_tlnb_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_lamp_red       (o_lamp_red),
    .o_lamp_yellow    (o_lamp_yellow),
    .o_lamp_green     (o_lamp_green),
    .o_display_write  (o_display_write),
    .o_display_digits (o_display_digits)
);
